### rtl/wpm_pkg.sv
// Shared types, constants and helper functions of the windowed peak/RMS level meter.
package wpm_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int SAMPLE_BITS  = 24;
  localparam int MAX_WINDOW   = 2048;

  localparam int CH_BITS    = $clog2(MAX_CHANNELS);
  localparam int CHANS_BITS = CH_BITS + 1;
  localparam int POS_BITS   = $clog2(MAX_WINDOW);
  localparam int LEN_BITS   = POS_BITS + 1;
  localparam int SQ_BITS    = 2 * SAMPLE_BITS;
  localparam int SUM_BITS   = 64;
  localparam int ROOT_BITS  = SUM_BITS / 2;
  localparam int STEP_BITS  = $clog2(SUM_BITS);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  localparam int CFG_IDX_BITS  = 4;
  localparam int CFG_DATA_BITS = 16;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_LENGTH   = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_CHANNELS_IN_USE = CFG_IDX_BITS'(1);

  localparam logic [LEN_BITS-1:0]   WINDOW_RESET = LEN_BITS'(480);
  localparam logic [CHANS_BITS-1:0] CHANS_RESET  = CHANS_BITS'(2);

  // Input mode codes
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_FLUSH  = 1'b1;

  typedef enum logic {
    CMD_SAMPLE,
    CMD_FLUSH
  } cmd_op_t;

  // One work item handed from the front end to the back end
  typedef struct packed {
    cmd_op_t                  op;
    logic [CH_BITS-1:0]       channel;
    logic [SAMPLE_BITS-1:0]   mag;
    logic                     window_end;
  } cmd_t;

  // Effective (clamped) configuration
  typedef struct packed {
    logic [LEN_BITS-1:0]   len;
    logic [CHANS_BITS-1:0] chans;
  } cfg_t;

  // Clamp window length to 1..MAX_WINDOW
  function automatic logic [LEN_BITS-1:0] eff_len(input logic [LEN_BITS-1:0] raw);
    logic [LEN_BITS-1:0] r;
    if (raw == '0) begin
      r = LEN_BITS'(1);
    end else if (raw > LEN_BITS'(MAX_WINDOW)) begin
      r = LEN_BITS'(MAX_WINDOW);
    end else begin
      r = raw;
    end
    return r;
  endfunction

  // Clamp channel count to 1..MAX_CHANNELS
  function automatic logic [CHANS_BITS-1:0] eff_chans(input logic [CHANS_BITS-1:0] raw);
    logic [CHANS_BITS-1:0] r;
    if (raw == '0) begin
      r = CHANS_BITS'(1);
    end else if (raw > CHANS_BITS'(MAX_CHANNELS)) begin
      r = CHANS_BITS'(MAX_CHANNELS);
    end else begin
      r = raw;
    end
    return r;
  endfunction

  // Absolute value; the most negative code maps to its unsigned magnitude
  function automatic logic [SAMPLE_BITS-1:0] magnitude(input logic [SAMPLE_BITS-1:0] s);
    logic [SAMPLE_BITS-1:0] m;
    if (s[SAMPLE_BITS-1]) begin
      m = SAMPLE_BITS'(~s + 1'b1);
    end else begin
      m = s;
    end
    return m;
  endfunction

endpackage

### rtl/wpm_sample_if.sv
// Input channel carrying audio samples and hold flush ticks.
interface wpm_sample_if import wpm_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [CH_BITS-1:0]            channel;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output mode, output channel, output sample, input ready);
  modport sink   (input valid, input mode, input channel, input sample, output ready);
endinterface

### rtl/wpm_level_if.sv
// Output channel carrying per-channel level results.
interface wpm_level_if import wpm_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CH_BITS-1:0]     out_channel;
  logic [SAMPLE_BITS-1:0] peak;
  logic [SAMPLE_BITS-1:0] rms;
  logic [SAMPLE_BITS-1:0] held_peak;
  logic                   last;

  modport source (output valid, output out_channel, output peak, output rms,
                  output held_peak, output last, input ready);
  modport sink   (input valid, input out_channel, input peak, input rms,
                  input held_peak, input last, output ready);
endinterface

### rtl/wpm_cfg_if.sv
// Configuration write channel.
interface wpm_cfg_if import wpm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/wpm_front.sv
// Front end: accepts items, classifies them and tracks the frame position of the window.
module wpm_front import wpm_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  wpm_sample_if.sink    samples,
  input  cfg_t          cfg,
  input  logic          queue_full,
  output logic          push,
  output cmd_t          push_cmd
);

  logic [POS_BITS-1:0] frame_pos;
  logic [LEN_BITS-1:0] pos_inc;
  logic [CH_BITS-1:0]  last_ch;
  logic                accept;
  logic                is_flush;
  logic                active;
  logic                frame_end;
  logic                window_end;

  assign samples.ready = !queue_full;
  assign accept        = samples.valid && samples.ready;

  // Classify the item
  assign is_flush   = (samples.mode == MODE_FLUSH);
  assign active     = ({1'b0, samples.channel} < cfg.chans);
  assign last_ch    = CH_BITS'(cfg.chans - 1'b1);
  assign frame_end  = (samples.channel == last_ch);
  assign pos_inc    = {1'b0, frame_pos} + 1'b1;
  assign window_end = frame_end && (pos_inc >= cfg.len);

  // Queue flush ticks and active samples; drop inactive channels
  assign push = accept && (is_flush || active);

  always_comb begin
    push_cmd.op         = is_flush ? CMD_FLUSH : CMD_SAMPLE;
    push_cmd.channel    = samples.channel;
    push_cmd.mag        = magnitude(samples.sample);
    push_cmd.window_end = !is_flush && window_end;
  end

  // Advance the frame count on each completed frame, wrap at window end
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_pos <= '0;
    end else if (accept && !is_flush && active && frame_end) begin
      frame_pos <= window_end ? '0 : pos_inc[POS_BITS-1:0];
    end
  end

endmodule

### rtl/wpm_queue.sv
// Short command queue between the front end and the back end.
module wpm_queue import wpm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic not_empty
);

  cmd_t                entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;
  logic                 do_push;
  logic                 do_pop;

  assign full      = (count == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_cmd   = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // Store payload at the write pointer
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/wpm_rms_unit.sv
// Iterative mean and root unit: divides a square sum by the window length, one quotient
// bit per cycle, then takes the floor square root, one root bit per cycle.
module wpm_rms_unit import wpm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [SUM_BITS-1:0]    sum,
  input  logic [LEN_BITS-1:0]    len,
  output logic                   done,
  output logic [SAMPLE_BITS-1:0] rms
);

  typedef enum logic [1:0] {
    R_IDLE,
    R_DIV,
    R_SQRT
  } rstate_t;

  rstate_t               state;
  logic [SUM_BITS-1:0]   work;
  logic [LEN_BITS-1:0]   divisor;
  logic [LEN_BITS-1:0]   rem_d;
  logic [ROOT_BITS-1:0]  root;
  logic [ROOT_BITS-1:0]  rem_s;
  logic [STEP_BITS-1:0]  step;

  logic [LEN_BITS:0]     div_shift;
  logic [LEN_BITS:0]     div_diff;
  logic                  div_bit;
  logic [ROOT_BITS+1:0]  sq_shift;
  logic [ROOT_BITS+1:0]  sq_trial;
  logic [ROOT_BITS+1:0]  sq_diff;
  logic                  sq_bit;

  // One restoring divide step
  always_comb begin
    div_shift = {rem_d, work[SUM_BITS-1]};
    div_diff  = div_shift - {1'b0, divisor};
    div_bit   = (div_shift >= {1'b0, divisor});
  end

  // One digit-pair square root step
  always_comb begin
    sq_shift = {rem_s, work[SUM_BITS-1 -: 2]};
    sq_trial = {root, 2'b01};
    sq_diff  = sq_shift - sq_trial;
    sq_bit   = (sq_shift >= sq_trial);
  end

  assign rms = root[SAMPLE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= R_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        R_IDLE: begin
          if (start) begin
            work    <= sum;
            divisor <= len;
            rem_d   <= '0;
            step    <= STEP_BITS'(SUM_BITS - 1);
            state   <= R_DIV;
          end
        end
        R_DIV: begin
          // Shift the quotient bit in as the dividend bit leaves
          rem_d <= div_bit ? div_diff[LEN_BITS-1:0] : div_shift[LEN_BITS-1:0];
          work  <= {work[SUM_BITS-2:0], div_bit};
          if (step == '0) begin
            root  <= '0;
            rem_s <= '0;
            step  <= STEP_BITS'(ROOT_BITS - 1);
            state <= R_SQRT;
          end else begin
            step <= step - 1'b1;
          end
        end
        R_SQRT: begin
          rem_s <= sq_bit ? sq_diff[ROOT_BITS-1:0] : sq_shift[ROOT_BITS-1:0];
          root  <= {root[ROOT_BITS-2:0], sq_bit};
          work  <= {work[SUM_BITS-3:0], 2'b00};
          if (step == '0) begin
            done  <= 1'b1;
            state <= R_IDLE;
          end else begin
            step <= step - 1'b1;
          end
        end
        default: begin
          state <= R_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/wpm_back.sv
// Back end: updates per-channel accumulators and emits the level results at window end.
module wpm_back import wpm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        pop,
  wpm_level_if.source levels
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACCUM,
    S_RMS_START,
    S_RMS_WAIT,
    S_EMIT
  } bstate_t;

  bstate_t                state;
  cmd_t                   cur;
  logic [SQ_BITS-1:0]     square;
  logic [CH_BITS-1:0]     idx;
  logic [SAMPLE_BITS-1:0] rms_val;
  logic [SAMPLE_BITS-1:0] peak_acc [MAX_CHANNELS];
  logic [SUM_BITS-1:0]    sum_acc  [MAX_CHANNELS];
  logic [SAMPLE_BITS-1:0] held     [MAX_CHANNELS];

  logic [SUM_BITS:0]      sum_ext;
  logic [SUM_BITS-1:0]    sum_sat;
  logic [SAMPLE_BITS-1:0] held_new;
  logic [CH_BITS-1:0]     last_ch;
  logic                   out_free;
  logic                   rms_start;
  logic                   rms_done;
  logic [SAMPLE_BITS-1:0] rms_root;

  assign pop       = (state == S_IDLE) && cmd_valid;
  assign last_ch   = CH_BITS'(cfg.chans - 1'b1);
  assign out_free  = !levels.valid || levels.ready;
  assign rms_start = (state == S_RMS_START);

  // Saturating add of the registered square
  always_comb begin
    sum_ext = {1'b0, sum_acc[cur.channel]} + (SUM_BITS+1)'(square);
    sum_sat = sum_ext[SUM_BITS] ? '1 : sum_ext[SUM_BITS-1:0];
  end

  // Held peak including the finished window
  assign held_new = (peak_acc[idx] > held[idx]) ? peak_acc[idx] : held[idx];

  wpm_rms_unit u_rms (
    .clk   (clk),
    .rst   (rst),
    .start (rms_start),
    .sum   (sum_acc[idx]),
    .len   (cfg.len),
    .done  (rms_done),
    .rms   (rms_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      levels.valid <= 1'b0;
      idx          <= '0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        peak_acc[i] <= '0;
        sum_acc[i]  <= '0;
        held[i]     <= '0;
      end
    end else begin
      // Drop the result once taken, unless the emit state loads the next one
      if (levels.valid && levels.ready && state != S_EMIT) begin
        levels.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur <= cmd;
            if (cmd.op == CMD_FLUSH) begin
              for (int i = 0; i < MAX_CHANNELS; i++) begin
                held[i] <= '0;
              end
            end else begin
              if (cmd.mag > peak_acc[cmd.channel]) begin
                peak_acc[cmd.channel] <= cmd.mag;
              end
              square <= cmd.mag * cmd.mag;
              state  <= S_ACCUM;
            end
          end
        end
        S_ACCUM: begin
          sum_acc[cur.channel] <= sum_sat;
          if (cur.window_end) begin
            idx   <= '0;
            state <= S_RMS_START;
          end else begin
            state <= S_IDLE;
          end
        end
        S_RMS_START: begin
          state <= S_RMS_WAIT;
        end
        S_RMS_WAIT: begin
          if (rms_done) begin
            rms_val <= rms_root;
            state   <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            levels.valid       <= 1'b1;
            levels.out_channel <= idx;
            levels.peak        <= peak_acc[idx];
            levels.rms         <= rms_val;
            levels.held_peak   <= held_new;
            levels.last        <= (idx == last_ch);
            held[idx]          <= held_new;
            if (idx == last_ch) begin
              // Window done: clear every accumulator
              for (int i = 0; i < MAX_CHANNELS; i++) begin
                peak_acc[i] <= '0;
                sum_acc[i]  <= '0;
              end
              state <= S_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_RMS_START;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/windowed_peak_rms_meter_core.sv
// Top level of the windowed peak/RMS level meter with peak hold.
//
//   port     | dir  | payload                                   | accepted when
//   ---------+------+-------------------------------------------+---------------------
//   samples  | in   | mode, channel, sample                     | valid && ready
//   levels   | out  | out_channel, peak, rms, held_peak, last   | valid && ready
//   cfg      | in   | index, data                               | valid && ready
//
// In the back end a sample is squared, then accumulated; a flush tick is handled when popped.
// At a window end each active channel takes 64 divide steps and 32 root
// steps in the shared mean/root unit, plus start, capture and emit.
// A 4-entry command queue lets samples keep arriving while the back end works.
// Reset (rst, synchronous) clears registers to their defaults and all accumulators.
// levels holds its result while ready is low; the back end stalls until it is taken.
module windowed_peak_rms_meter_core import wpm_pkg::*; (
  input logic         clk,
  input logic         rst,
  wpm_sample_if.sink  samples,
  wpm_level_if.source levels,
  wpm_cfg_if.sink     cfg
);

  logic [LEN_BITS-1:0]   window_length;
  logic [CHANS_BITS-1:0] channels_in_use;
  cfg_t                  cfg_eff;
  logic                  push;
  cmd_t                  push_cmd;
  logic                  queue_full;
  logic                  pop;
  cmd_t                  pop_cmd;
  logic                  cmd_valid;

  assign cfg.ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length   <= WINDOW_RESET;
      channels_in_use <= CHANS_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_WINDOW_LENGTH:   window_length   <= cfg.data[LEN_BITS-1:0];
        CFG_CHANNELS_IN_USE: channels_in_use <= cfg.data[CHANS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Clamp to the supported range
  assign cfg_eff.len   = eff_len(window_length);
  assign cfg_eff.chans = eff_chans(channels_in_use);

  wpm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .samples    (samples),
    .cfg        (cfg_eff),
    .queue_full (queue_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  wpm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (queue_full),
    .pop       (pop),
    .pop_cmd   (pop_cmd),
    .not_empty (cmd_valid)
  );

  wpm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_eff),
    .cmd_valid (cmd_valid),
    .cmd       (pop_cmd),
    .pop       (pop),
    .levels    (levels)
  );

endmodule
